FILE: hw/rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Shared widths, payload types and register codes for the bearing cross
// residual block.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int RES_WIDTH   = 17;
  localparam int FRAC_BITS   = 16;
  localparam int MID_DEPTH   = 2;
  localparam int OUT_DEPTH   = 32;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [RES_WIDTH-1:0] RES_ONE = RES_WIDTH'(1) << FRAC_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   diff_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODEL_X = 2'd0,
    REG_MODEL_Y = 2'd1,
    REG_MODEL_Z = 2'd2
  } reg_index_t;

  typedef struct packed {
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t anchor_x;
    coord_t anchor_y;
    coord_t anchor_z;
  } in_t;

  typedef struct packed {
    logic [RES_WIDTH-1:0] residual;
    logic                 over_range;
  } out_t;

  // Classified item handed from the front part to the back part
  typedef struct packed {
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    diff_t  dif_x;
    diff_t  dif_y;
    diff_t  dif_z;
    logic   dir_nz;
  } mid_t;

endpackage

FILE: hw/rtl/brc_fifo.sv
// ----------------------------------------------------------------------------
// brc_fifo
// Small register queue with head data shown while not empty.
// ----------------------------------------------------------------------------
module brc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/brc_front.sv
// ----------------------------------------------------------------------------
// brc_front
// Holds the model position, takes items and forms the difference vector and
// the zero-direction flag.
// ----------------------------------------------------------------------------
module brc_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  brc_pkg::in_t                           in_item,
  input  logic                                   cfg_we,
  input  logic [brc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [brc_pkg::COORD_WIDTH-1:0]        cfg_data,
  input  logic                                   mid_full,
  output logic                                   mid_push,
  output brc_pkg::mid_t                          mid_item
);

  brc_pkg::coord_t model_x;
  brc_pkg::coord_t model_y;
  brc_pkg::coord_t model_z;
  logic            fr_valid;
  brc_pkg::mid_t   fr_item;
  brc_pkg::mid_t   fr_item_next;
  logic            advance;

  assign advance  = !fr_valid || !mid_full;
  assign full     = !advance;
  assign mid_push = fr_valid && !mid_full;
  assign mid_item = fr_item;

  always_comb begin
    fr_item_next.dir_x  = in_item.dir_x;
    fr_item_next.dir_y  = in_item.dir_y;
    fr_item_next.dir_z  = in_item.dir_z;
    fr_item_next.dif_x  = brc_pkg::diff_t'(model_x) - brc_pkg::diff_t'(in_item.anchor_x);
    fr_item_next.dif_y  = brc_pkg::diff_t'(model_y) - brc_pkg::diff_t'(in_item.anchor_y);
    fr_item_next.dif_z  = brc_pkg::diff_t'(model_z) - brc_pkg::diff_t'(in_item.anchor_z);
    fr_item_next.dir_nz = |{in_item.dir_x, in_item.dir_y, in_item.dir_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model_x <= '0;
      model_y <= '0;
      model_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brc_pkg::REG_MODEL_X: model_x <= cfg_data;
        brc_pkg::REG_MODEL_Y: model_y <= cfg_data;
        brc_pkg::REG_MODEL_Z: model_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (advance) begin
      fr_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      fr_item <= fr_item_next;
    end
  end

endmodule

FILE: hw/rtl/brc_back.sv
// ----------------------------------------------------------------------------
// brc_back
// Cross product, squared lengths and a 17-step restoring divider, all
// pipelined; issues an item only when the result queue has room for it.
// ----------------------------------------------------------------------------
module brc_back #(
  parameter int OUT_DEPTH = brc_pkg::OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mid_empty,
  input  brc_pkg::mid_t                  mid_item,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_push,
  output brc_pkg::out_t                  res_item
);

  localparam int W    = brc_pkg::COORD_WIDTH;
  localparam int PW   = 2*W + 1;
  localparam int MW   = 2*W + 1;
  localparam int L    = (MW + 1) / 2;
  localparam int H    = MW - L;
  localparam int SQW  = 2*MW;
  localparam int CW   = SQW + 2;
  localparam int DSW  = 2*W + 2;
  localparam int DW   = DSW + 2;
  localparam int SHM  = 2*brc_pkg::FRAC_BITS;
  localparam int XW   = (CW > DW + SHM) ? CW : DW + SHM;
  localparam int NQ   = brc_pkg::RES_WIDTH;
  localparam int CNTW = $clog2(OUT_DEPTH+1);

  logic            issue;
  logic [CNTW-1:0] inflight;

  // stage 1: products
  logic                  v1, tnz1;
  logic signed [PW-1:0]  pa [3];
  logic signed [PW-1:0]  pb [3];
  logic signed [DSW-1:0] dsq [3];
  // stage 2: cross magnitudes and squared length
  logic                  v2, tnz2;
  logic [MW-1:0]         mag [3];
  logic [DW-1:0]         d2;
  logic signed [PW:0]    crs [3];
  // stage 3: partial squares
  logic                  v3, tnz3, dz3;
  logic [DW-1:0]         d3;
  logic [2*H-1:0]        hh [3];
  logic [H+L-1:0]        hl [3];
  logic [2*L-1:0]        ll [3];
  // stage 4: component squares
  logic                  v4, tnz4, dz4;
  logic [DW-1:0]         d4;
  logic [SQW-1:0]        sq [3];
  // stage 5: cross length squared
  logic                  v5, tnz5, dz5;
  logic [DW-1:0]         d5;
  logic [CW-1:0]         c5;
  // divider stages
  logic                  dv_v   [NQ];
  logic                  dv_tnz [NQ];
  logic                  dv_dz  [NQ];
  logic                  dv_ovr [NQ];
  logic [XW-1:0]         dv_rem [NQ];
  logic [DW-1:0]         dv_dd  [NQ];
  logic [NQ-1:0]         dv_q   [NQ];

  assign issue   = !mid_empty &&
                   (({1'b0, inflight} + {1'b0, out_count}) < (CNTW+1)'(OUT_DEPTH));
  assign mid_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNTW'(issue) - CNTW'(res_push);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crs[i] = {pa[i][PW-1], pa[i]} - {pb[i][PW-1], pb[i]};
    end
  end

  always_ff @(posedge clk) begin
    tnz1  <= mid_item.dir_nz;
    pa[0] <= mid_item.dir_y * mid_item.dif_z;
    pb[0] <= mid_item.dir_z * mid_item.dif_y;
    pa[1] <= mid_item.dir_z * mid_item.dif_x;
    pb[1] <= mid_item.dir_x * mid_item.dif_z;
    pa[2] <= mid_item.dir_x * mid_item.dif_y;
    pb[2] <= mid_item.dir_y * mid_item.dif_x;
    dsq[0] <= mid_item.dif_x * mid_item.dif_x;
    dsq[1] <= mid_item.dif_y * mid_item.dif_y;
    dsq[2] <= mid_item.dif_z * mid_item.dif_z;

    tnz2 <= tnz1;
    for (int i = 0; i < 3; i++) begin
      mag[i] <= crs[i][PW] ? MW'(-crs[i]) : MW'(crs[i]);
    end
    d2 <= DW'(unsigned'(dsq[0])) + DW'(unsigned'(dsq[1])) + DW'(unsigned'(dsq[2]));

    tnz3 <= tnz2;
    dz3  <= (d2 == '0);
    d3   <= d2;
    for (int i = 0; i < 3; i++) begin
      hh[i] <= mag[i][MW-1:L] * mag[i][MW-1:L];
      hl[i] <= mag[i][MW-1:L] * mag[i][L-1:0];
      ll[i] <= mag[i][L-1:0]  * mag[i][L-1:0];
    end

    tnz4 <= tnz3;
    dz4  <= dz3;
    d4   <= d3;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= (SQW'(hh[i]) << (2*L)) + (SQW'(hl[i]) << (L+1)) + SQW'(ll[i]);
    end

    tnz5 <= tnz4;
    dz5  <= dz4;
    d5   <= d4;
    c5   <= CW'(sq[0]) + CW'(sq[1]) + CW'(sq[2]);
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < NQ; k++) begin : g_div
    logic          v_in, tnz_in, dz_in, ovr_in;
    logic [XW-1:0] rem_in;
    logic [DW-1:0] dd_in;
    logic [NQ-1:0] q_in;
    logic [XW-1:0] sub;
    logic          ge;

    if (k == 0) begin : g_head
      assign v_in   = v5;
      assign tnz_in = tnz5;
      assign dz_in  = dz5;
      assign rem_in = XW'(c5);
      assign dd_in  = d5;
      assign q_in   = '0;
      assign ovr_in = (rem_in > sub);
    end else begin : g_body
      assign v_in   = dv_v[k-1];
      assign tnz_in = dv_tnz[k-1];
      assign dz_in  = dv_dz[k-1];
      assign rem_in = dv_rem[k-1];
      assign dd_in  = dv_dd[k-1];
      assign q_in   = dv_q[k-1];
      assign ovr_in = dv_ovr[k-1];
    end

    assign sub = XW'(dd_in) << (SHM - k);
    assign ge  = (rem_in >= sub);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else begin
        dv_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dv_tnz[k] <= tnz_in;
      dv_dz[k]  <= dz_in;
      dv_ovr[k] <= ovr_in;
      dv_dd[k]  <= dd_in;
      dv_rem[k] <= ge ? rem_in - sub : rem_in;
      dv_q[k]   <= q_in | (NQ'(ge) << (NQ-1-k));
    end
  end

  assign res_push = dv_v[NQ-1];

  always_comb begin
    priority if (dv_dz[NQ-1]) begin
      res_item.residual   = dv_tnz[NQ-1] ? brc_pkg::RES_ONE : '0;
      res_item.over_range = 1'b0;
    end else if (dv_ovr[NQ-1]) begin
      res_item.residual   = brc_pkg::RES_ONE;
      res_item.over_range = 1'b1;
    end else begin
      res_item.residual   = dv_q[NQ-1];
      res_item.over_range = 1'b0;
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, inflight} + {1'b0, out_count}) <= (CNTW+1)'(OUT_DEPTH))
    else $error("result queue overcommitted");

  a_retire: assert property (@(posedge clk) disable iff (rst)
    res_push |-> inflight != '0)
    else $error("result retired with nothing in flight");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_item.residual <= brc_pkg::RES_ONE)
    else $error("residual above one");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_item.over_range) |-> res_item.residual == brc_pkg::RES_ONE)
    else $error("over range without saturation");

endmodule

FILE: hw/rtl/bearing_cross_residual.sv
// ----------------------------------------------------------------------------
// bearing_cross_residual
// Scores a correspondence: |t x d|^2 / |d|^2 with d = model - anchor, in Q1.16.
// ----------------------------------------------------------------------------
//  channel   ports                          transfer when
//  input     push, full, in_item            push && !full
//  result    empty, pop, out_item           pop && !empty
//  config    cfg_we, cfg_index, cfg_data    cfg_we
//
// One item per cycle sustained while the result queue has room; a result passes
// through the front register, the middle queue, 5 arithmetic stages and
// 17 divider stages (one quotient bit per stage) into the result queue.
// The back part issues only when the result queue has room, so a stalled pop
// backs up into the middle queue and then raises full.
// Reset is synchronous; it empties both queues and clears the model position.
// ----------------------------------------------------------------------------
module bearing_cross_residual #(
  parameter int MID_DEPTH = brc_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = brc_pkg::OUT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  brc_pkg::in_t                        in_item,
  output logic                                empty,
  input  logic                                pop,
  output brc_pkg::out_t                       out_item,
  input  logic                                cfg_we,
  input  logic [brc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [brc_pkg::COORD_WIDTH-1:0]     cfg_data
);

  localparam int MIDW = $bits(brc_pkg::mid_t);
  localparam int OUTW = $bits(brc_pkg::out_t);

  logic                           mid_push;
  logic                           mid_pop;
  logic                           mid_full;
  logic                           mid_empty;
  brc_pkg::mid_t                  mid_wr;
  logic [MIDW-1:0]                mid_rd;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                           res_push;
  brc_pkg::out_t                  res_item;
  logic [OUTW-1:0]                out_rd;
  logic                           out_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  brc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid_full  (mid_full),
    .mid_push  (mid_push),
    .mid_item  (mid_wr)
  );

  brc_fifo #(
    .WIDTH (MIDW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_wr),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .full    (mid_full),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  brc_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty || (mid_count == '0)),
    .mid_item  (brc_pkg::mid_t'(mid_rd)),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  brc_fifo #(
    .WIDTH (OUTW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push && !out_full),
    .wr_data (res_item),
    .pop     (pop),
    .rd_data (out_rd),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign out_item = brc_pkg::out_t'(out_rd);

endmodule

FILE: verif/bearing_cross_residual_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bearing_cross_residual_tb
// Streams correspondences through the residual scorer under several model
// positions and flow-control patterns. Each result is compared with an exact
// wide-integer scoring of the direction against the model-minus-anchor vector.
// ----------------------------------------------------------------------------
module bearing_cross_residual_tb;

  localparam logic [brc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 160;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  brc_pkg::in_t  in_item = '0;
  logic empty;
  logic pop = 1'b0;
  brc_pkg::out_t out_item;
  logic cfg_we = 1'b0;
  logic [brc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [brc_pkg::COORD_WIDTH-1:0]     cfg_data = '0;

  bearing_cross_residual u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  brc_pkg::coord_t pos_x = '0, pos_y = '0, pos_z = '0;
  brc_pkg::out_t   pending_scores[$];
  int     failures = 0;
  int     send_gap_pct = 0, pop_stall_pct = 0;
  bit     hold_req = 1'b0;
  int     hold_cnt = 0;
  int     idle_cycles = 0;
  int     n_scored = 0, n_saturated = 0, n_degenerate = 0;

  // Exact score of one correspondence against the current model position
  function automatic brc_pkg::out_t score(brc_pkg::in_t it);
    logic signed [32:0]  dx, dy, dz;
    logic signed [66:0]  cx, cy, cz;
    logic signed [135:0] wx, wy, wz, ex, ey, ez;
    logic [135:0] csum, dsum, q;
    brc_pkg::out_t r;
    dx = {pos_x[31], pos_x} - {it.anchor_x[31], it.anchor_x};
    dy = {pos_y[31], pos_y} - {it.anchor_y[31], it.anchor_y};
    dz = {pos_z[31], pos_z} - {it.anchor_z[31], it.anchor_z};
    cx = 67'(it.dir_y) * 67'(dz) - 67'(it.dir_z) * 67'(dy);
    cy = 67'(it.dir_z) * 67'(dx) - 67'(it.dir_x) * 67'(dz);
    cz = 67'(it.dir_x) * 67'(dy) - 67'(it.dir_y) * 67'(dx);
    wx = cx; wy = cy; wz = cz;
    ex = dx; ey = dy; ez = dz;
    csum = wx * wx + wy * wy + wz * wz;
    dsum = ex * ex + ey * ey + ez * ez;
    r = '0;
    if (dsum == 0) begin
      r.residual = (it.dir_x != 0 || it.dir_y != 0 || it.dir_z != 0) ?
                   brc_pkg::RES_ONE : '0;
    end else if (csum > (dsum << 32)) begin
      r.residual   = brc_pkg::RES_ONE;
      r.over_range = 1'b1;
    end else begin
      q = csum / (dsum << 16);
      r.residual = q[brc_pkg::RES_WIDTH-1:0];
    end
    return r;
  endfunction

  // Record an expectation at every input transfer
  always @(posedge clk) begin
    if (!rst && push && !full) pending_scores.push_back(score(in_item));
  end

  // Result side: check, stall and watchdog
  always @(posedge clk) begin
    brc_pkg::out_t want;
    bit   acc;
    acc = 1'b0;
    if (!rst && pop && !empty) begin
      acc = 1'b1;
      n_scored++;
      if (out_item.over_range) n_saturated++;
      if (pending_scores.size() == 0) begin
        $error("unexpected result residual=%0d over_range=%0d",
               out_item.residual, out_item.over_range);
        failures++;
      end else begin
        want = pending_scores.pop_front();
        if (out_item.residual !== want.residual) begin
          $error("residual: expected %0d actual %0d", want.residual, out_item.residual);
          failures++;
        end
        if (out_item.over_range !== want.over_range) begin
          $error("over_range: expected %0d actual %0d",
                 want.over_range, out_item.over_range);
          failures++;
        end
      end
    end
    if (!rst && push && !full) acc = 1'b1;
    idle_cycles = acc ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("bearing_cross_residual test failed");
      $finish;
    end
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Offer one item, holding push high across back-to-back transfers
  task automatic send(input brc_pkg::in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  // Write all registers plus the unused index, enable held high throughout
  task automatic set_model(input brc_pkg::coord_t mx, input brc_pkg::coord_t my,
                           input brc_pkg::coord_t mz);
    brc_pkg::coord_t vals[3];
    vals = '{mx, my, mz};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= brc_pkg::reg_index_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_index <= REG_UNUSED;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    pos_x = mx; pos_y = my; pos_z = mz;
  endtask

  function automatic brc_pkg::coord_t pick_coord();
    case ($urandom_range(5))
      0: return brc_pkg::coord_t'($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
      1: return brc_pkg::coord_t'($signed($urandom_range(262144)) - 131072);
      2: return '0;
      default: return brc_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic brc_pkg::in_t random_item();
    brc_pkg::in_t it;
    it.dir_x = pick_coord(); it.dir_y = pick_coord(); it.dir_z = pick_coord();
    it.anchor_x = pick_coord(); it.anchor_y = pick_coord(); it.anchor_z = pick_coord();
    case ($urandom_range(9))
      0: begin
        // degenerate: anchor on the model position
        it.anchor_x = pos_x; it.anchor_y = pos_y; it.anchor_z = pos_z;
      end
      1: begin
        it.dir_x = '0; it.dir_y = '0; it.dir_z = '0;
      end
      2: begin
        // direction along the difference, scaled: near-zero residual
        it.dir_x = brc_pkg::coord_t'(pos_x - it.anchor_x) >>> 1;
        it.dir_y = brc_pkg::coord_t'(pos_y - it.anchor_y) >>> 1;
        it.dir_z = brc_pkg::coord_t'(pos_z - it.anchor_z) >>> 1;
      end
      default: ;
    endcase
    return it;
  endfunction

  typedef struct {
    brc_pkg::in_t  item;
    bit            known;
    brc_pkg::out_t want;
  } vector_t;

  localparam brc_pkg::coord_t ONE_Q = 32'sd65536;
  localparam brc_pkg::coord_t CMAX  = 32'h7fff_ffff;
  localparam brc_pkg::coord_t CMIN  = 32'h8000_0000;

  vector_t vectors[$];

  initial begin
    vector_t v;
    brc_pkg::in_t it;
    brc_pkg::coord_t mdl[3];

    // model at the origin after reset, so d = -anchor
    vectors.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{'0, 1'b0}});
    vectors.push_back('{'{CMAX, CMIN, 5, 0, 0, 0}, 1, '{brc_pkg::RES_ONE, 1'b0}});
    vectors.push_back('{'{0, 0, 0, 7, -3, 9}, 1, '{'0, 1'b0}});
    vectors.push_back('{'{ONE_Q, 0, 0, -ONE_Q, 0, 0}, 1, '{'0, 1'b0}});
    vectors.push_back('{'{0, ONE_Q, 0, -ONE_Q, 0, 0}, 1, '{brc_pkg::RES_ONE, 1'b0}});
    vectors.push_back('{'{0, 2 * ONE_Q, 0, -ONE_Q, 0, 0}, 1, '{brc_pkg::RES_ONE, 1'b1}});
    vectors.push_back('{'{ONE_Q, ONE_Q, 0, -ONE_Q, 0, 0}, 0, '{'0, 1'b0}});
    vectors.push_back('{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, 0, '{'0, 1'b0}});
    vectors.push_back('{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 0, '{'0, 1'b0}});
    vectors.push_back('{'{CMIN, CMAX, CMIN, CMIN, CMAX, 0}, 0, '{'0, 1'b0}});
    vectors.push_back('{'{1, 0, 0, 0, -1, 0}, 0, '{'0, 1'b0}});
    vectors.push_back('{'{1, 2, 3, CMAX, 0, CMIN}, 0, '{'0, 1'b0}});
    vectors.push_back('{'{-1, -1, -1, -1, -1, -1}, 0, '{'0, 1'b0}});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) begin
      v = vectors[i];
      if (v.known && score(v.item) != v.want) begin
        $error("table row %0d: residual expected %0d predicted %0d",
               i, v.want.residual, score(v.item).residual);
        failures++;
      end
      send(v.item);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: mdl = '{CMAX, CMAX, CMAX};
        1: mdl = '{CMIN, CMIN, CMIN};
        2: mdl = '{ONE_Q, -ONE_Q, 0};
        3: mdl = '{brc_pkg::coord_t'($urandom), brc_pkg::coord_t'($urandom),
                   brc_pkg::coord_t'($urandom)};
        default: mdl = '{0, 0, 0};
      endcase
      set_model(mdl[0], mdl[1], mdl[2]);
      send_gap_pct  = (ph % 4 == 1) ? 70 : (ph % 4 == 3) ? 37 : 0;
      pop_stall_pct = (ph % 4 == 2) ? 70 : (ph % 4 == 3) ? 37 : 0;
      // long receiver hold-off so the block fills and raises full
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) drain();
        it = random_item();
        send(it);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (pending_scores.size() != 0) begin
      $error("%0d expected results never arrived", pending_scores.size());
      failures++;
    end
    $display("Scored %0d correspondences over 6 model positions, %0d saturated.",
             n_scored, n_saturated);
    $display("Flow control covered free-running, sparse input, stalled output and full.");
    if (failures == 0) begin
      $display("bearing_cross_residual test passed");
    end else begin
      $display("bearing_cross_residual test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/brc_pkg.sv
hw/rtl/brc_fifo.sv
hw/rtl/brc_front.sv
hw/rtl/brc_back.sv
hw/rtl/bearing_cross_residual.sv
verif/bearing_cross_residual_tb.sv
